### hdl/fljs_pkg.sv
// ----------------------------------------------------------------------------
// fljs_pkg: shared definitions for the FCFS/LCFS job scheduler
// Queue sizing, command and status codes, register indexes and word types.
// ----------------------------------------------------------------------------
package fljs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] HORIZON_RESET = 8'd250;

  typedef enum logic {
    CMD_ARRIVAL = 1'b0,
    CMD_TICK    = 1'b1
  } command_t;

  typedef enum logic {
    ST_DONE    = 1'b0,
    ST_DROPPED = 1'b1
  } status_t;

  typedef enum logic {
    CFG_LIFO_MODE    = 1'b0,
    CFG_TIME_HORIZON = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  arrival;
    logic [7:0]  length;
  } job_t;

  typedef struct packed {
    status_t     status;
    job_t        job;
    logic [7:0]  start_time;
    logic [8:0]  end_time;
    logic [7:0]  waiting_time;
    logic [8:0]  turnaround;
  } result_t;

endpackage

### hdl/fcfs_lcfs_job_scheduler.sv
// ----------------------------------------------------------------------------
// fcfs_lcfs_job_scheduler: non-preemptive single-server job scheduler
// Queues arriving jobs and serves them oldest-first or newest-first on ticks.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   in_*      input      in_valid/in_stall  command, job_id, arrival_time, run_length
//   out_*     output     out_valid/out_stall status, done_*, times
//   cfg_*     input      cfg_we             cfg_index, cfg_data
//
// One word is taken per cycle while in_stall is low; its result, if any, is
// registered into the output register, or into the skid entry while the
// output is held. All queue and timing work is done in the accept cycle, so
// the rate is one word per clock while in_stall is low. A two-entry output
// buffer (output register plus skid) lets a word enter while a result waits;
// in_stall rises only while both entries are full. Reset is synchronous and active low; queue contents are not cleared.
//
module fcfs_lcfs_job_scheduler
  import fljs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [15:0] in_job_id,
  input  logic [7:0]  in_arrival_time,
  input  logic [7:0]  in_run_length,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [15:0] out_done_id,
  output logic [7:0]  out_done_arrival,
  output logic [7:0]  out_done_length,
  output logic [7:0]  out_start_time,
  output logic [8:0]  out_end_time,
  output logic [7:0]  out_waiting_time,
  output logic [8:0]  out_turnaround
);

  // Configuration.
  logic       lifo_r;
  logic [7:0] horizon_r;

  // Queue storage and pointers.
  job_t             queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] head_r, tail_r;
  logic [CNT_W-1:0] count_r;

  // Server state.
  logic       busy_r;
  job_t       run_r;
  logic [7:0] run_start_r;
  logic [7:0] now_r;

  // Output buffer.
  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;

  logic             accept, is_arrival, full, drop, push;
  logic             tick_live, start_job, finish, res_valid;
  logic [PTR_W-1:0] head_inc, tail_inc, tail_dec, pop_slot;
  job_t             cur_job, in_job;
  logic [7:0]       cur_start, elapsed, wait_time;
  result_t          res;

  logic [PTR_W-1:0] head_nxt, tail_nxt;
  logic [CNT_W-1:0] count_nxt;
  logic             busy_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    ptr_dec = (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  assign in_stall   = skid_valid_r;
  assign accept     = in_valid && !in_stall;
  assign is_arrival = (in_command == CMD_ARRIVAL);
  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign drop       = accept && is_arrival && full;
  assign push       = accept && is_arrival && !full;
  assign in_job     = '{id: in_job_id, arrival: in_arrival_time, length: in_run_length};

  assign head_inc = ptr_inc(head_r);
  assign tail_inc = ptr_inc(tail_r);
  assign tail_dec = ptr_dec(tail_r);
  assign pop_slot = lifo_r ? tail_dec : head_r;

  assign tick_live = accept && !is_arrival && (now_r < horizon_r);
  assign start_job = tick_live && !busy_r && (count_r != '0);

  // A job started on this tick may also finish on it when its length is one.
  assign cur_job   = start_job ? queue_r[pop_slot] : run_r;
  assign cur_start = start_job ? now_r : run_start_r;
  assign elapsed   = now_r - cur_start;
  assign finish    = tick_live && (busy_r || start_job)
                     && (elapsed == cur_job.length - 8'd1);
  assign wait_time = cur_start - cur_job.arrival;
  assign res_valid = drop || finish;

  always_comb begin
    if (drop) begin
      res = '{status: ST_DROPPED, job: in_job, start_time: '0, end_time: '0,
              waiting_time: '0, turnaround: '0};
    end else begin
      res = '{status: ST_DONE, job: cur_job, start_time: cur_start,
              end_time: {1'b0, now_r} + 9'd1, waiting_time: wait_time,
              turnaround: {1'b0, wait_time} + {1'b0, cur_job.length}};
    end
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    busy_nxt  = busy_r;
    if (push) begin
      tail_nxt  = tail_inc;
      count_nxt = count_r + 1'b1;
    end
    if (start_job) begin
      count_nxt = count_r - 1'b1;
      if (lifo_r) begin
        tail_nxt = tail_dec;
      end else begin
        head_nxt = head_inc;
      end
    end
    if (tick_live) begin
      busy_nxt = (busy_r || start_job) && !finish;
    end
  end

  // Queue entries carry no reset; only written slots are ever read.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[tail_r] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifo_r       <= 1'b0;
      horizon_r    <= HORIZON_RESET;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      busy_r       <= 1'b0;
      run_r        <= '0;
      run_start_r  <= '0;
      now_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_LIFO_MODE:    lifo_r    <= cfg_data[0];
          CFG_TIME_HORIZON: horizon_r <= cfg_data;
          default:          ;
        endcase
      end
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      busy_r  <= busy_nxt;
      if (start_job) begin
        run_r       <= cur_job;
        run_start_r <= now_r;
      end
      if (tick_live) begin
        now_r <= now_r + 8'd1;
      end

      // The skid entry only fills while the output register is held, and
      // the input stalls while it is full.
      if (!out_valid_r || !out_stall) begin
        out_valid_r  <= skid_valid_r || res_valid;
        skid_valid_r <= 1'b0;
      end else if (res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_done_id      = out_r.job.id;
  assign out_done_arrival = out_r.job.arrival;
  assign out_done_length  = out_r.job.length;
  assign out_start_time   = out_r.start_time;
  assign out_end_time     = out_r.end_time;
  assign out_waiting_time = out_r.waiting_time;
  assign out_turnaround   = out_r.turnaround;

  // The queue never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // Pointers meet exactly when the queue is empty or full.
  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == tail_r) == ((count_r == '0) || (count_r == CNT_W'(QUEUE_DEPTH))))
    else $error("queue pointers disagree with count");

  // A full skid entry always sits behind a full output register.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry filled while output register empty");

  // Time only advances on a live tick.
  a_now_step: assert property (@(posedge clk) disable iff (!rst_n)
    !tick_live |=> $stable(now_r))
    else $error("time advanced without a live tick");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the FCFS/LCFS job scheduler
// Sends job arrivals and time ticks through the valid/stall channel, predicts
// every completion and every dropped arrival, and compares each report field
// by field. Runs several register settings, random idling on both channels
// and one long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
  import fljs_pkg::*;

  localparam int LIMIT = 100000;

  class sched_scoreboard;
    bit          lifo;
    logic [7:0]  horizon;
    job_t        slots [QUEUE_DEPTH];
    int          head;
    int          count;
    bit          busy;
    job_t        running;
    logic [7:0]  run_start;
    logic [7:0]  clock_now;
    result_t     reports_due [$];
    int          mismatches;

    function new();
      lifo       = 1'b0;
      horizon    = HORIZON_RESET;
      head       = 0;
      count      = 0;
      busy       = 1'b0;
      running    = '0;
      run_start  = '0;
      clock_now  = '0;
      mismatches = 0;
    endfunction

    function void add_report(result_t rep);
      reports_due.insert(reports_due.size(), rep);
    endfunction

    function result_t take_report();
      result_t rep;
      rep = reports_due[0];
      reports_due.delete(0);
      return rep;
    endfunction

    // Returns 0 for a tick that the block ignores.
    function bit note_word(command_t cmd, job_t job);
      result_t    rep;
      int         slot;
      logic [7:0] elapsed;
      logic [7:0] last_tick;
      logic [7:0] wait_t;
      rep = '0;
      if (cmd == CMD_ARRIVAL) begin
        if (count >= QUEUE_DEPTH) begin
          rep.status = ST_DROPPED;
          rep.job    = job;
          add_report(rep);
        end else begin
          slots[(head + count) % QUEUE_DEPTH] = job;
          count++;
        end
        return 1'b1;
      end
      if (clock_now >= horizon) return 1'b0;
      if (!busy && count > 0) begin
        if (lifo) begin
          slot = (head + count - 1) % QUEUE_DEPTH;
        end else begin
          slot = head;
          head = (head + 1) % QUEUE_DEPTH;
        end
        count--;
        running   = slots[slot];
        run_start = clock_now;
        busy      = 1'b1;
      end
      elapsed   = clock_now - run_start;
      last_tick = running.length - 8'd1;
      if (busy && elapsed == last_tick) begin
        // The waiting time wraps when the job claims to arrive after its start.
        wait_t           = run_start - running.arrival;
        rep.status       = ST_DONE;
        rep.job          = running;
        rep.start_time   = run_start;
        rep.end_time     = {1'b0, clock_now} + 9'd1;
        rep.waiting_time = wait_t;
        rep.turnaround   = {1'b0, wait_t} + {1'b0, running.length};
        add_report(rep);
        busy = 1'b0;
      end
      clock_now++;
      return 1'b1;
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= 50)
          $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 50)
          $display("%0t: report with none expected, expected nothing, got id %0d status %0d",
                   $time, got.job.id, got.status);
        return;
      end
      want = take_report();
      compare("status", want.status, got.status);
      compare("done_id", want.job.id, got.job.id);
      compare("done_arrival", want.job.arrival, got.job.arrival);
      compare("done_length", want.job.length, got.job.length);
      compare("start_time", want.start_time, got.start_time);
      compare("end_time", want.end_time, got.end_time);
      compare("waiting_time", want.waiting_time, got.waiting_time);
      compare("turnaround", want.turnaround, got.turnaround);
    endfunction
  endclass

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        cfg_we          = 1'b0;
  logic        cfg_index       = 1'b0;
  logic [7:0]  cfg_data        = 8'd0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic        in_command      = 1'b0;
  logic [15:0] in_job_id       = 16'd0;
  logic [7:0]  in_arrival_time = 8'd0;
  logic [7:0]  in_run_length   = 8'd1;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic        out_status;
  logic [15:0] out_done_id;
  logic [7:0]  out_done_arrival;
  logic [7:0]  out_done_length;
  logic [7:0]  out_start_time;
  logic [8:0]  out_end_time;
  logic [7:0]  out_waiting_time;
  logic [8:0]  out_turnaround;

  sched_scoreboard board;
  bit              jitter_on    = 1'b1;
  bit              hold_request = 1'b0;
  int              stall_left   = 0;
  int              cycles       = 0;

  fcfs_lcfs_job_scheduler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_job_id        (in_job_id),
    .in_arrival_time  (in_arrival_time),
    .in_run_length    (in_run_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_done_id      (out_done_id),
    .out_done_arrival (out_done_arrival),
    .out_done_length  (out_done_length),
    .out_start_time   (out_start_time),
    .out_end_time     (out_end_time),
    .out_waiting_time (out_waiting_time),
    .out_turnaround   (out_turnaround)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("** fcfs_lcfs_job_scheduler: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_report(result_t'({out_status, out_done_id, out_done_arrival,
                                    out_done_length, out_start_time, out_end_time,
                                    out_waiting_time, out_turnaround}));
    end
  end

  // Result side: short random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = 79;
        out_stall <= 1'b1;
      end else if (jitter_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic set_regs(bit lifo, logic [7:0] horizon);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LIFO_MODE;
    cfg_data  <= {7'd0, lifo};
    @(posedge clk);
    cfg_index <= CFG_TIME_HORIZON;
    cfg_data  <= horizon;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.lifo    = lifo;
    board.horizon = horizon;
  endtask

  // Offers one word after an optional gap; the prediction is updated on accept.
  task automatic offer(command_t cmd, job_t job, output bit counted);
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_job_id       <= job.id;
    in_arrival_time <= job.arrival;
    in_run_length   <= job.length;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    counted = board.note_word(cmd, job);
  endtask

  task automatic drain();
    while (board.reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(int quota, int tick_pct, bit jitter, int noise_len);
    int       taken;
    int       sent;
    int       pct;
    bit       counted;
    command_t cmd;
    job_t     job;
    taken = 0;
    sent  = 0;
    while (taken < quota) begin
      if (sent % 40 == 0) jitter_on = jitter && ($urandom_range(0, 2) != 0);
      sent++;
      // Once the horizon is reached, ticks only stall time, so favor arrivals.
      pct = (board.clock_now < board.horizon) ? tick_pct : 10;
      cmd = ($urandom_range(0, 99) < pct) ? CMD_TICK : CMD_ARRIVAL;
      job.id = 16'($urandom_range(0, 16'hFFFF));
      if ($urandom_range(0, 7) == 0) begin
        job.arrival = 8'($urandom_range(0, 255));
        job.length  = 8'($urandom_range(1, noise_len));
      end else begin
        job.arrival = board.clock_now;
        job.length  = 8'($urandom_range(1, 6));
      end
      offer(cmd, job, counted);
      if (counted) taken++;
    end
    in_valid <= 1'b0;
    drain();
  endtask

  initial begin
    bit counted;
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: only the tick at time zero is inside a horizon of one.
    set_regs(1'b0, 8'd1);
    offer(CMD_ARRIVAL, job_t'{16'hFFFF, 8'd0, 8'd1}, counted);
    offer(CMD_ARRIVAL, job_t'{16'h0000, 8'd255, 8'd2}, counted);
    offer(CMD_TICK, job_t'{16'h1234, 8'd7, 8'd9}, counted);
    offer(CMD_TICK, job_t'{16'h0000, 8'd0, 8'd1}, counted);
    for (int i = 0; i < 15; i++)
      offer(CMD_ARRIVAL, job_t'{16'(i), 8'(i * 17), 8'd3}, counted);
    offer(CMD_ARRIVAL, job_t'{16'hFFFF, 8'd255, 8'd255}, counted);
    offer(CMD_ARRIVAL, job_t'{16'h0000, 8'd0, 8'd1}, counted);
    in_valid <= 1'b0;
    drain();

    // The first mode flip comes while the queue is full of waiting jobs.
    set_regs(1'b1, 8'd30);
    run_phase(175, 45, 1'b1, 24);
    set_regs(1'b0, 8'd70);
    run_phase(175, 60, 1'b1, 24);
    set_regs(1'b1, 8'd110);
    hold_request = 1'b1;
    run_phase(175, 20, 1'b1, 24);
    set_regs(1'b0, 8'd150);
    run_phase(175, 40, 1'b1, 24);
    set_regs(1'b1, 8'd200);
    run_phase(175, 50, 1'b1, 24);
    set_regs(1'b0, 8'd255);
    run_phase(175, 40, 1'b0, 255);

    if (board.mismatches == 0)
      $display("** fcfs_lcfs_job_scheduler: PASSED **");
    else
      $display("** fcfs_lcfs_job_scheduler: FAILED **");
    $finish;
  end

endmodule
